@@ rtl/core/gbda_pkg.sv @@
// Shared types, register indexes and lookup tables for the grid box decoder.
`timescale 1ns / 1ps
`default_nettype none
package gbda_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_SCMP,
    ST_CMUL,
    ST_CDST,
    ST_CDWT,
    ST_EMUL1,
    ST_EMUL2,
    ST_EMUL3,
    ST_ESAT,
    ST_EMIT
  } st_t;

  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_PRIOR_W   = 2'd1;
  localparam logic [1:0] CFG_PRIOR_H   = 2'd2;

  localparam int NUM_W = 22;

  // Sigmoid at half-unit steps, Q0.16.
  function automatic logic [15:0] sig_tab(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:  v = 16'd32768;
      5'd1:  v = 16'd40793;
      5'd2:  v = 16'd47911;
      5'd3:  v = 16'd53581;
      5'd4:  v = 16'd57724;
      5'd5:  v = 16'd60564;
      5'd6:  v = 16'd62428;
      5'd7:  v = 16'd63615;
      5'd8:  v = 16'd64357;
      5'd9:  v = 16'd64816;
      5'd10: v = 16'd65097;
      5'd11: v = 16'd65269;
      5'd12: v = 16'd65374;
      5'd13: v = 16'd65438;
      5'd14: v = 16'd65476;
      5'd15: v = 16'd65500;
      5'd16: v = 16'd65514;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // e^n for n = -8..7, Q.20, indexed by n + 8.
  function automatic logic [30:0] exp_int(input logic [3:0] idx);
    logic [30:0] v;
    unique case (idx)
      4'd0:  v = 31'd352;
      4'd1:  v = 31'd956;
      4'd2:  v = 31'd2599;
      4'd3:  v = 31'd7065;
      4'd4:  v = 31'd19205;
      4'd5:  v = 31'd52206;
      4'd6:  v = 31'd141909;
      4'd7:  v = 31'd385750;
      4'd8:  v = 31'd1048576;
      4'd9:  v = 31'd2850325;
      4'd10: v = 31'd7747987;
      4'd11: v = 31'd21061212;
      4'd12: v = 31'd57250310;
      4'd13: v = 31'd155622477;
      4'd14: v = 31'd423025750;
      4'd15: v = 31'd1149903210;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // e^(k/8) for k = 0..8, Q.16.
  function automatic logic [17:0] exp_frac(input logic [3:0] idx);
    logic [17:0] v;
    unique case (idx)
      4'd0: v = 18'd65536;
      4'd1: v = 18'd74262;
      4'd2: v = 18'd84150;
      4'd3: v = 18'd95354;
      4'd4: v = 18'd108051;
      4'd5: v = 18'd122437;
      4'd6: v = 18'd138740;
      4'd7: v = 18'd157213;
      4'd8: v = 18'd178145;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/gbda_div.sv @@
// Restoring divider, one quotient bit per cycle, for the box centre scaling.
`timescale 1ns / 1ps
`default_nettype none
module gbda_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [gbda_pkg::NUM_W-1:0]  num,
  input  wire logic [4:0]                  den,
  output logic                             done,
  output logic [gbda_pkg::NUM_W-1:0]       quot
);

  logic [4:0] rem;
  logic [4:0] cnt;
  logic       run;
  logic [5:0] rem_sh;
  logic       fits;

  assign rem_sh = {rem, quot[gbda_pkg::NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(gbda_pkg::NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (run) begin
      // The remainder stays below the divisor, so five bits hold it.
      rem  <= fits ? 5'(rem_sh - {1'b0, den}) : rem_sh[4:0];
      quot <= {quot[gbda_pkg::NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/grid_box_decode_argmax.sv @@
// Top level: best-cell search over a prediction grid and decode of its box.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  cell in  | start / busy       | score/x/y/w/h_logit, cell_row, cell_col
//  result   | done (one cycle)   | best_score_out, box_xmin/ymin/xmax/ymax
//  config   | cfg_we             | cfg_index, cfg_data
//
// A cell passes through a sigmoid multiply, a compare and a return to idle. The
// last cell of the grid adds the decode: per axis one sigmoid multiply and
// three exp multiplies on one shared 32x18 multiplier, and a restoring
// divide by the grid size.
// Reset is synchronous and clears the control state and running best.
// The result is marked by done for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module grid_box_decode_argmax #(
  parameter int MAX_GRID = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] score_logit,
  input  wire logic [15:0] x_logit,
  input  wire logic [15:0] y_logit,
  input  wire logic [15:0] w_logit,
  input  wire logic [15:0] h_logit,
  input  wire logic [3:0]  cell_row,
  input  wire logic [3:0]  cell_col,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             done,
  output logic [15:0]      best_score_out,
  output logic [15:0]      box_xmin,
  output logic [15:0]      box_ymin,
  output logic [15:0]      box_xmax,
  output logic [15:0]      box_ymax
);

  localparam int GLIM = (MAX_GRID > 16) ? 16 : MAX_GRID;
  localparam logic [4:0] GLIM5 = 5'(GLIM);

  gbda_pkg::st_t state, state_next;

  logic [4:0]  grid_size;
  logic [15:0] prior_w, prior_h;

  logic [15:0] in_score, in_x, in_y, in_w, in_h;
  logic [3:0]  in_row, in_col;

  logic [15:0] best_score, best_x_raw, best_y_raw, best_w_raw, best_h_raw;
  logic [3:0]  best_row, best_col;

  logic        dim;
  logic [49:0] prod;
  logic [21:0] cx2, cy2;
  logic [17:0] w_sat, h_sat;

  logic [4:0]  g;
  logic        in_grid, last_cell;

  // Sigmoid interpolation
  logic [15:0] sig_raw, sig_a, sig_base, sig_diff, sig_val;
  logic        sig_neg;
  logic [4:0]  sig_idx;
  logic [10:0] sig_fr;
  logic [16:0] sig_s;

  // Exp interpolation
  logic [15:0] ex_u, prior;
  logic [3:0]  ex_seg;
  logic [8:0]  ex_fr;
  logic [17:0] f_base, f_diff, ef;
  logic [27:0] e16;
  logic [29:0] vq;
  logic [17:0] v_sat;

  logic [31:0] mul_a;
  logic [17:0] mul_b;

  logic        div_start, div_done;
  logic [21:0] div_num, div_quot;

  always_comb begin
    if (grid_size == 5'd0) begin
      g = 5'd1;
    end else if (grid_size > GLIM5) begin
      g = GLIM5;
    end else begin
      g = grid_size;
    end
  end

  assign in_grid   = ({1'b0, in_row} < g) && ({1'b0, in_col} < g);
  assign last_cell = ({1'b0, in_row} == 5'(g - 5'd1)) && ({1'b0, in_col} == 5'(g - 5'd1));

  assign sig_raw  = (state == gbda_pkg::ST_SMUL || state == gbda_pkg::ST_SCMP) ? in_score :
                    (dim ? best_y_raw : best_x_raw);
  assign sig_neg  = sig_raw[15];
  assign sig_a    = sig_neg ? 16'(~sig_raw + 16'd1) : sig_raw;
  assign sig_idx  = sig_a[15:11];
  assign sig_fr   = sig_a[10:0];
  assign sig_base = gbda_pkg::sig_tab(sig_idx);
  assign sig_diff = (sig_idx >= 5'd16) ? 16'd0 :
                    16'(gbda_pkg::sig_tab(5'(sig_idx + 5'd1)) - sig_base);
  assign sig_s    = {1'b0, sig_base} + 17'((prod[27:0] + 28'd1024) >> 11);
  assign sig_val  = sig_neg ? 16'(17'd65536 - sig_s) : sig_s[15:0];

  // Adding 8 flips the top bit, giving floor(x) + 8 above the fraction.
  assign ex_u   = (dim ? best_h_raw : best_w_raw) ^ 16'h8000;
  assign ex_seg = {1'b0, ex_u[11:9]};
  assign ex_fr  = ex_u[8:0];
  assign f_base = gbda_pkg::exp_frac(ex_seg);
  assign f_diff = 18'(gbda_pkg::exp_frac(4'(ex_seg + 4'd1)) - f_base);
  assign ef     = f_base + 18'((prod[24:0] + 25'd256) >> 9);
  assign e16    = 28'((prod + 50'h80000) >> 20);
  assign prior  = dim ? prior_h : prior_w;
  assign vq     = 30'((prod[43:0] + 44'h2000) >> 14);
  assign v_sat  = (vq > 30'd131072) ? 18'd131072 : 18'(vq);

  assign div_num = (22'(best_col & {4{~dim}} | best_row & {4{dim}}) << 17)
                   + (22'(sig_val) << 1);

  gbda_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (g),
    .done (div_done),
    .quot (div_quot)
  );

  function automatic logic [15:0] edge_clip(input logic signed [23:0] v);
    logic [15:0] r;
    if (v <= 24'sd0) begin
      r = 16'd0;
    end else if (v >= 24'sd131072) begin
      r = 16'd32768;
    end else begin
      r = 16'((v + 24'sd2) >>> 2);
    end
    return r;
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbda_pkg::ST_IDLE:  if (start) state_next = gbda_pkg::ST_SMUL;
      gbda_pkg::ST_SMUL:  state_next = gbda_pkg::ST_SCMP;
      gbda_pkg::ST_SCMP: begin
        if (in_grid && last_cell) state_next = gbda_pkg::ST_CMUL;
        else state_next = gbda_pkg::ST_IDLE;
      end
      gbda_pkg::ST_CMUL:  state_next = gbda_pkg::ST_CDST;
      gbda_pkg::ST_CDST:  state_next = gbda_pkg::ST_CDWT;
      gbda_pkg::ST_CDWT:  if (div_done) state_next = gbda_pkg::ST_EMUL1;
      gbda_pkg::ST_EMUL1: state_next = gbda_pkg::ST_EMUL2;
      gbda_pkg::ST_EMUL2: state_next = gbda_pkg::ST_EMUL3;
      gbda_pkg::ST_EMUL3: state_next = gbda_pkg::ST_ESAT;
      gbda_pkg::ST_ESAT:  state_next = dim ? gbda_pkg::ST_EMIT : gbda_pkg::ST_CMUL;
      gbda_pkg::ST_EMIT:  state_next = gbda_pkg::ST_IDLE;
      default:            state_next = gbda_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands and control outputs
  always_comb begin
    mul_a     = {16'd0, sig_diff};
    mul_b     = {7'd0, sig_fr};
    div_start = 1'b0;
    busy      = (state != gbda_pkg::ST_IDLE);
    unique case (state)
      gbda_pkg::ST_EMUL1: begin
        mul_a = {14'd0, f_diff};
        mul_b = {9'd0, ex_fr};
      end
      gbda_pkg::ST_EMUL2: begin
        mul_a = {1'b0, gbda_pkg::exp_int(ex_u[15:12])};
        mul_b = ef;
      end
      gbda_pkg::ST_EMUL3: begin
        mul_a = {4'd0, e16};
        mul_b = {2'd0, prior};
      end
      gbda_pkg::ST_CDST: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbda_pkg::ST_IDLE;
      grid_size  <= 5'd13;
      prior_w    <= 16'd16384;
      prior_h    <= 16'd16384;
      best_score <= '0;
      best_x_raw <= '0;
      best_y_raw <= '0;
      best_w_raw <= '0;
      best_h_raw <= '0;
      best_row   <= '0;
      best_col   <= '0;
      dim        <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == gbda_pkg::ST_EMIT);
      if (cfg_we) begin
        unique case (cfg_index)
          gbda_pkg::CFG_GRID_SIZE: grid_size <= cfg_data[4:0];
          gbda_pkg::CFG_PRIOR_W:   prior_w   <= cfg_data;
          gbda_pkg::CFG_PRIOR_H:   prior_h   <= cfg_data;
          default: ;
        endcase
      end
      if (state == gbda_pkg::ST_SCMP && in_grid &&
          ((in_row == 4'd0 && in_col == 4'd0) || sig_val > best_score)) begin
        best_score <= sig_val;
        best_x_raw <= in_x;
        best_y_raw <= in_y;
        best_w_raw <= in_w;
        best_h_raw <= in_h;
        best_row   <= in_row;
        best_col   <= in_col;
      end
      if (state == gbda_pkg::ST_SCMP) dim <= 1'b0;
      else if (state == gbda_pkg::ST_ESAT) dim <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gbda_pkg::ST_IDLE && start) begin
      in_score <= score_logit;
      in_x     <= x_logit;
      in_y     <= y_logit;
      in_w     <= w_logit;
      in_h     <= h_logit;
      in_row   <= cell_row;
      in_col   <= cell_col;
    end
    if (state == gbda_pkg::ST_SMUL || state == gbda_pkg::ST_CMUL ||
        state == gbda_pkg::ST_EMUL1 || state == gbda_pkg::ST_EMUL2 ||
        state == gbda_pkg::ST_EMUL3) begin
      prod <= 50'(mul_a) * 50'(mul_b);
    end
    if (state == gbda_pkg::ST_CDWT && div_done) begin
      if (dim) cy2 <= div_quot;
      else cx2 <= div_quot;
    end
    if (state == gbda_pkg::ST_ESAT) begin
      if (dim) h_sat <= v_sat;
      else w_sat <= v_sat;
    end
    if (state == gbda_pkg::ST_EMIT) begin
      best_score_out <= best_score;
      box_xmin <= edge_clip(24'(signed'({2'b0, cx2})) - 24'(signed'({6'b0, w_sat})));
      box_ymin <= edge_clip(24'(signed'({2'b0, cy2})) - 24'(signed'({6'b0, h_sat})));
      box_xmax <= edge_clip(24'(signed'({2'b0, cx2})) + 24'(signed'({6'b0, w_sat})));
      box_ymax <= edge_clip(24'(signed'({2'b0, cy2})) + 24'(signed'({6'b0, h_sat})));
    end
  end

endmodule
`default_nettype wire

@@ test/grid_box_decode_argmax_test.sv @@
// Self-checking testbench for the grid box decoder with a cycle-free predictor.
`timescale 1ns / 1ps
module grid_box_decode_argmax_test;

  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int GRID_CAP = 16;

  typedef struct {
    logic [15:0] sc, xl, yl, wl, hl;
    logic [3:0]  row, col;
  } cell_t;

  typedef struct {
    logic [15:0] score, xmin, ymin, xmax, ymax;
  } box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] score_logit = '0, x_logit = '0, y_logit = '0, w_logit = '0, h_logit = '0;
  logic [3:0] cell_row = '0, cell_col = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic [15:0] best_score_out, box_xmin, box_ymin, box_xmax, box_ymax;

  grid_box_decode_argmax dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .score_logit(score_logit), .x_logit(x_logit), .y_logit(y_logit),
    .w_logit(w_logit), .h_logit(h_logit), .cell_row(cell_row), .cell_col(cell_col),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .best_score_out(best_score_out), .box_xmin(box_xmin),
    .box_ymin(box_ymin), .box_xmax(box_xmax), .box_ymax(box_ymax)
  );

  initial forever #4 clk = ~clk;

  cell_t cells[$];
  box_t  boxes_due[$];
  cell_t drv_cell;
  int    send_idle = 0;
  int    errors = 0;
  logic  took = 1'b0;

  // Shadow configuration and running best.
  logic [4:0]  m_grid;
  logic [15:0] m_pw, m_ph;
  logic [15:0] b_score, b_x, b_y, b_w, b_h;
  logic [3:0]  b_row, b_col;

  longint unsigned sig_pts[17] = '{32768, 40793, 47911, 53581, 57724, 60564, 62428,
    63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
  longint unsigned eint[16] = '{352, 956, 2599, 7065, 19205, 52206, 141909, 385750,
    1048576, 2850325, 7747987, 21061212, 57250310, 155622477, 423025750, 1149903210};
  longint unsigned efrac[9] = '{65536, 74262, 84150, 95354, 108051, 122437, 138740,
    157213, 178145};

  function automatic longint unsigned sigmoid_q16(logic [15:0] raw);
    longint unsigned a, idx, fr, s;
    a = raw[15] ? (65536 - raw) : raw;
    idx = a >> 11;
    fr = a & 2047;
    if (idx >= 16) s = sig_pts[16];
    else s = sig_pts[idx] + (((sig_pts[idx + 1] - sig_pts[idx]) * fr + 1024) >> 11);
    return raw[15] ? (65536 - s) : s;
  endfunction

  function automatic longint unsigned box_extent(logic [15:0] raw, logic [15:0] prior);
    logic [15:0] u;
    longint unsigned seg, fr, ef, e16, v;
    u = raw + 16'h8000;
    seg = u[11:9];
    fr = u[8:0];
    ef = efrac[seg] + (((efrac[seg + 1] - efrac[seg]) * fr + 256) >> 9);
    e16 = (eint[u[15:12]] * ef + (64'd1 << 19)) >> 20;
    v = (e16 * prior + 8192) >> 14;
    return (v > 131072) ? 131072 : v;
  endfunction

  function automatic logic [15:0] clip_edge(longint v);
    if (v <= 0) return 16'd0;
    if (v >= 131072) return 16'd32768;
    return 16'((v + 2) >> 2);
  endfunction

  function automatic int grid_in_use();
    if (m_grid == 0) return 1;
    if (m_grid > GRID_CAP) return GRID_CAP;
    return m_grid;
  endfunction

  // Updates the running best for one accepted cell and queues a box on the last cell.
  function automatic void track_cell(cell_t c);
    int g;
    longint unsigned s;
    longint cx2, cy2, w, h;
    box_t bx;
    g = grid_in_use();
    if (c.row >= g || c.col >= g) return;
    s = sigmoid_q16(c.sc);
    if ((c.row == 0 && c.col == 0) || s > b_score) begin
      b_score = 16'(s);
      b_x = c.xl; b_y = c.yl; b_w = c.wl; b_h = c.hl;
      b_row = c.row; b_col = c.col;
    end
    if (c.row != g - 1 || c.col != g - 1) return;
    cx2 = longint'((2 * ((longint'(b_col) << 16) + sigmoid_q16(b_x))) / g);
    cy2 = longint'((2 * ((longint'(b_row) << 16) + sigmoid_q16(b_y))) / g);
    w = box_extent(b_w, m_pw);
    h = box_extent(b_h, m_ph);
    bx.score = b_score;
    bx.xmin = clip_edge(cx2 - w);
    bx.ymin = clip_edge(cy2 - h);
    bx.xmax = clip_edge(cx2 + w);
    bx.ymax = clip_edge(cy2 + h);
    boxes_due.insert(boxes_due.size(), bx);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: a new item goes up only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cells.size() > 0 && $urandom_range(99) >= send_idle) begin
        drv_cell = cells.pop_front();
        start <= 1'b1;
        score_logit <= drv_cell.sc; x_logit <= drv_cell.xl; y_logit <= drv_cell.yl;
        w_logit <= drv_cell.wl; h_logit <= drv_cell.hl;
        cell_row <= drv_cell.row; cell_col <= drv_cell.col;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on acceptance and checks each strobed result.
  always @(posedge clk) begin
    box_t want;
    cell_t c;
    took <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (boxes_due.size() == 0) begin
          report("result with nothing expected, score", best_score_out, 16'd0);
        end else begin
          want = boxes_due.pop_front();
          if (best_score_out !== want.score) report("score", best_score_out, want.score);
          if (box_xmin !== want.xmin) report("xmin", box_xmin, want.xmin);
          if (box_ymin !== want.ymin) report("ymin", box_ymin, want.ymin);
          if (box_xmax !== want.xmax) report("xmax", box_xmax, want.xmax);
          if (box_ymax !== want.ymax) report("ymax", box_ymax, want.ymax);
        end
      end
      if (start && !busy) begin
        c.sc = score_logit; c.xl = x_logit; c.yl = y_logit; c.wl = w_logit;
        c.hl = h_logit; c.row = cell_row; c.col = cell_col;
        track_cell(c);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gbda_pkg::CFG_GRID_SIZE) m_grid = val[4:0];
    else if (idx == gbda_pkg::CFG_PRIOR_W) m_pw = val;
    else if (idx == gbda_pkg::CFG_PRIOR_H) m_ph = val;
  endtask

  // Waits until every item is taken and every box has come, then lets the decode drain.
  task automatic settle();
    while (cells.size() != 0 || start || boxes_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_logit();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(16'($urandom_range(8191)) - 16'd4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cell_t make_cell(int r, int c);
    cell_t x;
    x.sc = pick_logit(); x.xl = pick_logit(); x.yl = pick_logit();
    x.wl = pick_logit(); x.hl = pick_logit();
    x.row = 4'(r); x.col = 4'(c);
    return x;
  endfunction

  // One raster frame; a broken frame drops its first cell, and stray cells are mixed in.
  task automatic queue_frame(int g, bit broken);
    cell_t x;
    logic [15:0] last_sc;
    last_sc = 16'h0;
    for (int r = 0; r < g; r++) begin
      for (int c = 0; c < g; c++) begin
        if (!(broken && r == 0 && c == 0)) begin
          x = make_cell(r, c);
          if ($urandom_range(5) == 0) x.sc = last_sc;
          last_sc = x.sc;
          cells.insert(cells.size(), x);
        end
        if ($urandom_range(11) == 0)
          cells.insert(cells.size(), make_cell($urandom_range(15), $urandom_range(15)));
      end
    end
  endtask

  initial begin
    int modes[3];
    cell_t x;
    int g;
    modes = '{38, 45, 0};
    m_grid = 5'd13; m_pw = 16'd16384; m_ph = 16'd16384;
    b_score = '0; b_x = '0; b_y = '0; b_w = '0; b_h = '0; b_row = '0; b_col = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: a 1x1 grid emits only on cell 0,0, with the extremes of each field.
    write_reg(gbda_pkg::CFG_GRID_SIZE, 16'd0);
    write_reg(gbda_pkg::CFG_PRIOR_W, 16'd0);
    write_reg(gbda_pkg::CFG_PRIOR_H, 16'hFFFF);
    write_reg(CFG_NONE, 16'hFFFF);
    x = make_cell(0, 0);
    x.sc = 16'h8000; x.xl = 16'h8000; x.yl = 16'h7FFF; x.wl = 16'h7FFF; x.hl = 16'h8000;
    cells.insert(cells.size(), x);
    x.sc = 16'h7FFF; x.xl = 16'h7FFF; x.yl = 16'h8000; x.wl = 16'h8000; x.hl = 16'h7FFF;
    cells.insert(cells.size(), x);
    x.sc = 16'h0; x.xl = 16'h0; x.yl = 16'h0; x.wl = 16'h0; x.hl = 16'h0;
    cells.insert(cells.size(), x);
    x.row = 4'd15; x.col = 4'd15;
    cells.insert(cells.size(), x);
    x.row = 4'd0; x.col = 4'd1;
    cells.insert(cells.size(), x);
    settle();
    // Equal scores everywhere, so the first cell must be kept.
    write_reg(gbda_pkg::CFG_GRID_SIZE, 16'd2);
    write_reg(gbda_pkg::CFG_PRIOR_W, 16'd16384);
    write_reg(gbda_pkg::CFG_PRIOR_H, 16'd16384);
    for (int i = 0; i < 4; i++) begin
      x = make_cell(i / 2, i % 2);
      x.sc = 16'h1000;
      cells.insert(cells.size(), x);
    end
    // A frame with no first cell starts from the previous best.
    for (int i = 1; i < 4; i++) cells.insert(cells.size(), make_cell(i / 2, i % 2));
    settle();

    for (int p = 0; p < 7; p++) begin
      send_idle = modes[(p * 3) / 7];
      case ($urandom_range(5))
        0: g = $urandom_range(31);
        1: g = 1;
        default: g = $urandom_range(2, 4);
      endcase
      if (p == 6) g = 31;
      write_reg(gbda_pkg::CFG_GRID_SIZE, 16'(g));
      write_reg(gbda_pkg::CFG_PRIOR_W,
                (p == 1) ? 16'hFFFF : (p == 2) ? 16'h0 : 16'($urandom));
      write_reg(gbda_pkg::CFG_PRIOR_H,
                (p == 1) ? 16'h0 : (p == 2) ? 16'hFFFF : 16'($urandom));
      g = grid_in_use();
      if (p == 6) begin
        queue_frame(g, 1'b0);
      end else begin
        while (cells.size() < 20) queue_frame(g, $urandom_range(7) == 0);
      end
      settle();
    end

    if (errors == 0) $display("grid_box_decode_argmax: match");
    else $display("grid_box_decode_argmax: mismatch");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("grid_box_decode_argmax: mismatch");
    $finish;
  end

endmodule
